### src/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg - shared types, constants and functions of the 3x3 median filter
// Sizes of the line stores and counters, item codes, register indexes, the
// item passed from the window stage to the median stage, and the small
// compare helpers of the median network.
// ----------------------------------------------------------------------------
`default_nettype none

package mf3_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int HEIGHT_CAP  = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(HEIGHT_CAP);
    localparam int PIX_W       = 8;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 4;
    localparam int WIN         = 3;
    localparam int TAPS        = WIN * WIN;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [WIN-1:0]   trio_t;

    typedef struct packed {
        pix_t [TAPS-1:0] taps;
        logic            zero;
        logic            last;
    } win_item_t;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_status_t;

    function automatic pix_t pix_min(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t pix_max(input pix_t a, input pix_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return pix_max(pix_min(a, b), pix_min(pix_max(a, b), c));
    endfunction

    function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
        trio_t s;
        s[0] = pix_min(pix_min(a, b), c);
        s[1] = med3(a, b, c);
        s[2] = pix_max(pix_max(a, b), c);
        return s;
    endfunction

endpackage

`default_nettype wire

### src/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered (old data on a
// read of the address being written in the same cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### src/mf3_front.sv
// ----------------------------------------------------------------------------
// mf3_front - input side of the 3x3 median filter
// Accepts items, classifies them as pixel, flush or ignored, tracks input
// and output raster positions, runs the two line stores and the 3x3 window
// and pushes one window snapshot per result into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [mf3_pkg::PIX_W-1:0]      s_axis_tdata,   // pixel_in
    input  wire logic                           s_axis_tuser,   // kind
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mf3_pkg::CFG_W-1:0]      cfg_data,
    input  wire mf3_pkg::q_status_t             q_status,
    output logic                                push,
    output mf3_pkg::win_item_t                  push_item
);

    localparam int COL_W = mf3_pkg::COL_W;
    localparam int ROW_W = mf3_pkg::ROW_W;
    localparam int WIN   = mf3_pkg::WIN;

    logic [COL_W-1:0] wlast_reg, wlast_next;
    logic [ROW_W-1:0] hlast_reg, hlast_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             done_reg, done_next;
    logic [COL_W-1:0] ocol_reg, ocol_next;
    logic [ROW_W-1:0] orow_reg, orow_next;

    logic             s1_pix_reg;
    logic             s1_emit_reg;
    logic             s1_fwd_reg;
    logic             s1_zero_reg;
    logic             s1_last_reg;
    mf3_pkg::pix_t    s1_pixel_reg;
    logic [COL_W-1:0] s1_addr_reg;
    mf3_pkg::pix_t    fwd_up_reg;
    mf3_pkg::pix_t    fwd_mid_reg;

    mf3_pkg::pix_t [mf3_pkg::TAPS-1:0] win_reg, win_next;

    logic                      accept;
    logic                      is_pix;
    logic                      is_flush;
    logic                      emit;
    logic                      o_zero;
    logic                      o_last;
    logic                      fwd_next;
    logic                      cfg_wr;
    logic [mf3_pkg::QCNT_W-1:0] in_flight;
    mf3_pkg::pix_t             up_rd, mid_rd, up_val, mid_val;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign in_flight     = q_status.count + mf3_pkg::QCNT_W'(s1_emit_reg);
    assign s_axis_tready = in_flight < mf3_pkg::QCNT_W'(mf3_pkg::QUEUE_DEPTH);

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign is_pix   = accept && (s_axis_tuser == mf3_pkg::KIND_PIXEL) && !done_reg;
    assign is_flush = accept && (s_axis_tuser == mf3_pkg::KIND_FLUSH) && done_reg;
    assign emit     = is_flush ||
                      (is_pix && (row_reg != '0) &&
                       ((row_reg != ROW_W'(1)) || (col_reg != '0)));

    assign o_zero = !((orow_reg != '0) && (orow_reg < hlast_reg) &&
                      (ocol_reg != '0) && (ocol_reg < wlast_reg));
    assign o_last = (orow_reg == hlast_reg) && (ocol_reg == wlast_reg);

    assign fwd_next = is_pix && s1_pix_reg && (s1_addr_reg == col_reg);

    always_comb
    begin
        wlast_next = wlast_reg;
        hlast_next = hlast_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        done_next  = done_reg;
        ocol_next  = ocol_reg;
        orow_next  = orow_reg;
        if (cfg_wr)
        begin
            if (cfg_index == mf3_pkg::REG_FRAME_WIDTH)
            begin
                if (cfg_data == '0)
                    wlast_next = '0;
                else if (int'(cfg_data) > mf3_pkg::MAX_WIDTH)
                    wlast_next = COL_W'(mf3_pkg::MAX_WIDTH - 1);
                else
                    wlast_next = COL_W'(cfg_data - 1'b1);
            end
            if (cfg_index == mf3_pkg::REG_FRAME_HEIGHT)
            begin
                if (cfg_data == '0)
                    hlast_next = '0;
                else if (int'(cfg_data) > mf3_pkg::HEIGHT_CAP)
                    hlast_next = ROW_W'(mf3_pkg::HEIGHT_CAP - 1);
                else
                    hlast_next = ROW_W'(cfg_data - 1'b1);
            end
            if ((cfg_index == mf3_pkg::REG_FRAME_WIDTH) ||
                (cfg_index == mf3_pkg::REG_FRAME_HEIGHT))
            begin
                col_next  = '0;
                row_next  = '0;
                done_next = 1'b0;
                ocol_next = '0;
                orow_next = '0;
            end
        end
        else
        begin
            if (is_pix)
            begin
                if (col_reg == wlast_reg)
                begin
                    col_next = '0;
                    if (row_reg == hlast_reg)
                    begin
                        row_next  = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            if (emit)
            begin
                if (o_last)
                begin
                    col_next  = '0;
                    row_next  = '0;
                    done_next = 1'b0;
                    ocol_next = '0;
                    orow_next = '0;
                end
                else if (ocol_reg == wlast_reg)
                begin
                    ocol_next = '0;
                    orow_next = orow_reg + ROW_W'(1);
                end
                else
                begin
                    ocol_next = ocol_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg   <= COL_W'(640 - 1);
            hlast_reg   <= ROW_W'(480 - 1);
            col_reg     <= '0;
            row_reg     <= '0;
            done_reg    <= 1'b0;
            ocol_reg    <= '0;
            orow_reg    <= '0;
            s1_pix_reg  <= 1'b0;
            s1_emit_reg <= 1'b0;
            s1_fwd_reg  <= 1'b0;
            win_reg     <= '0;
        end
        else
        begin
            wlast_reg   <= wlast_next;
            hlast_reg   <= hlast_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            done_reg    <= done_next;
            ocol_reg    <= ocol_next;
            orow_reg    <= orow_next;
            s1_pix_reg  <= is_pix;
            s1_emit_reg <= emit;
            s1_fwd_reg  <= fwd_next;
            win_reg     <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_zero_reg  <= o_zero;
            s1_last_reg  <= o_last;
            s1_pixel_reg <= s_axis_tdata;
            s1_addr_reg  <= col_reg;
        end
        if (s1_pix_reg)
        begin
            fwd_up_reg  <= mid_val;
            fwd_mid_reg <= s1_pixel_reg;
        end
    end

    mf3_ram #(
        .WIDTH (mf3_pkg::PIX_W),
        .DEPTH (mf3_pkg::MAX_WIDTH)
    ) u_upper (
        .clk     (clk),
        .wr_en   (s1_pix_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (mid_val),
        .rd_en   (is_pix),
        .rd_addr (col_reg),
        .rd_data (up_rd)
    );

    mf3_ram #(
        .WIDTH (mf3_pkg::PIX_W),
        .DEPTH (mf3_pkg::MAX_WIDTH)
    ) u_middle (
        .clk     (clk),
        .wr_en   (s1_pix_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_pixel_reg),
        .rd_en   (is_pix),
        .rd_addr (col_reg),
        .rd_data (mid_rd)
    );

    assign up_val  = s1_fwd_reg ? fwd_up_reg  : up_rd;
    assign mid_val = s1_fwd_reg ? fwd_mid_reg : mid_rd;

    // shift the window left by one column and take in the new column
    always_comb
    begin
        win_next = win_reg;
        if (s1_pix_reg)
        begin
            for (int r = 0; r < WIN; r++)
            begin
                for (int k = 0; k < WIN - 1; k++)
                begin
                    win_next[r * WIN + k] = win_reg[r * WIN + k + 1];
                end
            end
            win_next[WIN - 1]       = up_val;
            win_next[2 * WIN - 1]   = mid_val;
            win_next[3 * WIN - 1]   = s1_pixel_reg;
        end
    end

    assign push           = s1_emit_reg;
    assign push_item.taps = win_next;
    assign push_item.zero = s1_zero_reg;
    assign push_item.last = s1_last_reg;

endmodule

`default_nettype wire

### src/mf3_queue.sv
// ----------------------------------------------------------------------------
// mf3_queue - short queue between window stage and median stage
// Holds window snapshots so that the input side and the output side stall
// independently.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire mf3_pkg::win_item_t push_item,
    input  wire logic               pop,
    output mf3_pkg::win_item_t      head_item,
    output mf3_pkg::q_status_t      q_status
);

    localparam int DEPTH  = mf3_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = mf3_pkg::QPTR_W;
    localparam int CNT_W  = mf3_pkg::QCNT_W;

    mf3_pkg::win_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item      = mem_reg[rd_ptr_reg];
    assign q_status.count = count_reg;
    assign q_status.empty = (count_reg == '0);

endmodule

`default_nettype wire

### src/mf3_back.sv
// ----------------------------------------------------------------------------
// mf3_back - median network and output register
// Sorts each window row, forms max of minima, median of medians and min of
// maxima, takes the median of those three and drives the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mf3_pkg::q_status_t         q_status,
    input  wire mf3_pkg::win_item_t         head_item,
    output logic                            pop,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [mf3_pkg::PIX_W-1:0]       m_axis_tdata,   // pixel_out
    output logic                            m_axis_tlast    // last
);

    localparam int WIN = mf3_pkg::WIN;

    logic                               advance;
    mf3_pkg::trio_t [WIN-1:0]           rows_sorted;

    logic                               b1_valid_reg;
    mf3_pkg::trio_t [WIN-1:0]           b1_rows_reg;
    logic                               b1_zero_reg;
    logic                               b1_last_reg;

    logic                               b2_valid_reg;
    mf3_pkg::pix_t                      b2_lo_reg, b2_mid_reg, b2_hi_reg;
    logic                               b2_zero_reg;
    logic                               b2_last_reg;

    logic                               out_valid_reg;
    mf3_pkg::pix_t                      out_pix_reg;
    logic                               out_last_reg;

    assign advance = !out_valid_reg || m_axis_tready;
    assign pop     = advance && !q_status.empty;

    always_comb
    begin
        for (int r = 0; r < WIN; r++)
        begin
            rows_sorted[r] = mf3_pkg::sort3(head_item.taps[r * WIN],
                                            head_item.taps[r * WIN + 1],
                                            head_item.taps[r * WIN + 2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b1_valid_reg  <= pop;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b1_rows_reg  <= rows_sorted;
            b1_zero_reg  <= head_item.zero;
            b1_last_reg  <= head_item.last;

            b2_lo_reg    <= mf3_pkg::pix_max(mf3_pkg::pix_max(b1_rows_reg[0][0],
                                                              b1_rows_reg[1][0]),
                                             b1_rows_reg[2][0]);
            b2_mid_reg   <= mf3_pkg::med3(b1_rows_reg[0][1], b1_rows_reg[1][1],
                                          b1_rows_reg[2][1]);
            b2_hi_reg    <= mf3_pkg::pix_min(mf3_pkg::pix_min(b1_rows_reg[0][2],
                                                              b1_rows_reg[1][2]),
                                             b1_rows_reg[2][2]);
            b2_zero_reg  <= b1_zero_reg;
            b2_last_reg  <= b1_last_reg;

            out_pix_reg  <= b2_zero_reg ? '0 : mf3_pkg::med3(b2_lo_reg, b2_mid_reg, b2_hi_reg);
            out_last_reg <= b2_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pix_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

### src/median_filter_3x3_top.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_top - streaming 3x3 median filter for 8-bit grey frames
// Input stream: s_axis_tdata carries a pixel, s_axis_tuser the item kind
// (pixel or flush). Output stream: m_axis_tdata carries the filtered pixel,
// m_axis_tlast marks the final pixel of the frame. Border pixels are zero.
// Configuration: cfg_index 0 writes the frame width, 1 the frame height;
// a write to either restarts the frame. cfg_ready is always high.
// Throughput: one item per clock while s_axis_tready is high. A result passes
// the line store read, the window update, the queue and the three-stage
// median network before it leaves the output register. Results lag the input
// by width+1 raster positions; after the last pixel, width+1 flush items
// release the remaining border pixels, the final one with tlast.
// Reset: counters, window and queue clear; width 640, height 480. The line
// stores are not cleared and need no clearing pass.
// Stall: when m_axis_tready is low the output holds and the median stages
// freeze; input keeps accepting until the four-entry queue between the window
// and median stages, with the item in flight, is full; then s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module median_filter_3x3_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [mf3_pkg::PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel_in
    input  wire logic                           s_axis_tuser,   // [0] kind
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [mf3_pkg::PIX_W-1:0]           m_axis_tdata,   // [7:0] pixel_out
    output logic                                m_axis_tlast,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mf3_pkg::CFG_W-1:0]      cfg_data
);

    logic               push;
    logic               pop;
    mf3_pkg::win_item_t push_item;
    mf3_pkg::win_item_t head_item;
    mf3_pkg::q_status_t q_status;

    mf3_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_status      (q_status),
        .push          (push),
        .push_item     (push_item)
    );

    mf3_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    mf3_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .head_item     (head_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### src/mf3_checker.sv
// ----------------------------------------------------------------------------
// mf3_checker - port-level checks of the 3x3 median filter
// Watches the top-level ports and reports violations; bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_axis_tready,
    input wire logic                      m_axis_tvalid,
    input wire logic                      m_axis_tready,
    input wire logic [mf3_pkg::PIX_W-1:0] m_axis_tdata,
    input wire logic                      m_axis_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    a_last_is_border: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata == '0))
        else $error("final pixel of frame is not a zero border pixel");

    a_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !m_axis_tvalid)
        else $error("output valid straight after reset");

    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> s_axis_tready)
        else $error("input not ready straight after reset");

endmodule

bind median_filter_3x3_top mf3_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench - 3x3 median filter under random frames and stream back-pressure
// Streams frames of varied size and content through median_filter_3x3_top:
// the reset frame size, tiny and clamped sizes, the start of the widest rows,
// aborted frames, stray flush and pixel items. A behavioural copy of the
// filter, with its own line stores, window and raster counters, works out
// each filtered pixel and its tlast; the output stream is compared against
// it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import mf3_pkg::*;

    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int SETTLE_CYCLES     = 20;
    localparam int RANDOM_ITEMS      = 440;
    localparam int PARTIAL_ROW_ITEMS = 24;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;

    typedef struct packed {
        logic kind;
        pix_t pixel;
    } stream_item_t;

    typedef struct packed {
        pix_t pixel;
        logic last;
    } filtered_pixel_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [PIX_W-1:0]     s_axis_tdata = '0;   // [7:0] pixel_in
    logic                 s_axis_tuser = KIND_PIXEL;   // [0] kind
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [PIX_W-1:0]     m_axis_tdata;   // [7:0] pixel_out
    logic                 m_axis_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // filter state as the block should hold it
    logic [CFG_W-1:0] frame_w = CFG_W'(640);
    logic [CFG_W-1:0] frame_h = CFG_W'(480);
    pix_t             upper_line [MAX_WIDTH];
    pix_t             middle_line [MAX_WIDTH];
    pix_t             win [TAPS];
    int unsigned      raster_col = 0;
    int unsigned      raster_row = 0;
    int unsigned      out_index = 0;
    bit               frame_complete = 1'b0;

    stream_item_t     pending_items [$];
    filtered_pixel_t  owed_pixels [$];
    int unsigned      pushed_count = 0;
    int unsigned      accepted_count = 0;
    int unsigned      random_items = 0;
    int               error_count = 0;
    int               quiet_cycles = 0;
    int               src_hold = 0;
    int               sink_hold = 0;
    int               src_mode = 1;
    int               sink_mode = 1;
    bit               calm = 1'b0;

    median_filter_3x3_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] value, input int cap);
        if (value == 0)
            return 1;
        if (value > cap)
            return cap;
        return value;
    endfunction

    function automatic void restart_frame();
        raster_col     = 0;
        raster_row     = 0;
        out_index      = 0;
        frame_complete = 1'b0;
    endfunction

    function automatic pix_t window_median();
        int below;
        int not_above;
        for (int i = 0; i < TAPS; i++)
        begin
            below     = 0;
            not_above = 0;
            for (int j = 0; j < TAPS; j++)
            begin
                if (win[j] < win[i])
                    below++;
                if (win[j] <= win[i])
                    not_above++;
            end
            if (below <= TAPS / 2 && not_above > TAPS / 2)
                return win[i];
        end
        return '0;
    endfunction

    function automatic void emit_pixel(input int unsigned w, input int unsigned h);
        filtered_pixel_t r;
        int unsigned     qr;
        int unsigned     qc;
        qr = out_index / w;
        qc = out_index % w;
        r.pixel = (qr >= 1 && qr + 1 < h && qc >= 1 && qc + 1 < w) ? window_median() : '0;
        r.last  = (out_index + 1 >= w * h);
        owed_pixels.push_back(r);
        if (r.last)
            restart_frame();
        else
            out_index++;
    endfunction

    function automatic void filter_accept(input logic kind, input pix_t pixel);
        int unsigned w;
        int unsigned h;
        int unsigned pos;
        w = clamp_dim(frame_w, MAX_WIDTH);
        h = clamp_dim(frame_h, HEIGHT_CAP);
        if (kind == KIND_FLUSH)
        begin
            if (frame_complete)
                emit_pixel(w, h);
        end
        else if (!frame_complete)
        begin
            for (int r = 0; r < WIN; r++)
            begin
                win[r * WIN]     = win[r * WIN + 1];
                win[r * WIN + 1] = win[r * WIN + 2];
            end
            win[WIN - 1]           = upper_line[raster_col];
            win[2 * WIN - 1]       = middle_line[raster_col];
            win[TAPS - 1]          = pixel;
            upper_line[raster_col] = middle_line[raster_col];
            middle_line[raster_col] = pixel;
            pos = raster_row * w + raster_col;
            raster_col++;
            if (raster_col >= w)
            begin
                raster_col = 0;
                raster_row++;
                if (raster_row >= h)
                begin
                    raster_row     = 0;
                    frame_complete = 1'b1;
                end
            end
            if (pos >= w + 1)
                emit_pixel(w, h);
        end
    endfunction

    function automatic bit roll_gap(input int mode);
        if (calm || mode == 0)
            return 1'b0;
        return (mode == 1) ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 3) == 0);
    endfunction

    function automatic pix_t random_pixel(input int style);
        if (style == 0)
            return $urandom_range(0, 1) ? pix_t'(255) : pix_t'(0);
        if (style == 1)
            return pix_t'($urandom_range(100, 103));
        return pix_t'($urandom_range(0, 255));
    endfunction

    task automatic push_item(input logic kind, input pix_t pixel);
        stream_item_t it;
        it.kind  = kind;
        it.pixel = pixel;
        pending_items.push_back(it);
        pushed_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
        begin
            frame_w = value;
            restart_frame();
        end
        else if (idx == REG_FRAME_HEIGHT)
        begin
            frame_h = value;
            restart_frame();
        end
    endtask

    task automatic wait_idle();
        while (accepted_count != pushed_count || owed_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // raster-order frame then width+1 flushes, or an aborted start; noise adds strays
    task automatic queue_frame(input int unsigned w, input int unsigned h,
                               input bit noisy, input bit aborted);
        int unsigned total;
        int unsigned stop;
        int          style;
        total = w * h;
        stop  = aborted ? $urandom_range(0, total - 1) : total;
        style = $urandom_range(0, 3);
        for (int unsigned i = 0; i < stop; i++)
        begin
            if (noisy && i + 1 < total && $urandom_range(0, 15) == 0)
                push_item(KIND_FLUSH, random_pixel(2));
            push_item(KIND_PIXEL, random_pixel(style));
            random_items++;
        end
        if (!aborted)
        begin
            for (int unsigned f = 0; f <= w; f++)
            begin
                if (noisy && $urandom_range(0, 7) == 0)
                    push_item(KIND_PIXEL, random_pixel(2));
                push_item(KIND_FLUSH, random_pixel(2));
                random_items++;
            end
            if (noisy && $urandom_range(0, 3) == 0)
                push_item(KIND_FLUSH, random_pixel(2));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= KIND_PIXEL;
            src_hold      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                filter_accept(s_axis_tuser, s_axis_tdata);
                accepted_count++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_hold > 0)
                begin
                    src_hold      <= src_hold - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_items[0].pixel;
                    s_axis_tuser  <= pending_items[0].kind;
                    void'(pending_items.pop_front());
                    if (roll_gap(src_mode))
                        src_hold <= $urandom_range(1, 11);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            if ($urandom_range(0, 63) == 0)
                src_mode <= $urandom_range(0, 2);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_check
        filtered_pixel_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_hold     <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (owed_pixels.size() == 0)
                begin
                    $error("unexpected item: pixel_out %0d last %0b", m_axis_tdata, m_axis_tlast);
                    error_count++;
                end
                else
                begin
                    want = owed_pixels.pop_front();
                    if (m_axis_tdata !== want.pixel)
                    begin
                        $error("pixel_out: expected %0d, actual %0d", want.pixel, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            if (sink_hold > 0)
            begin
                sink_hold     <= sink_hold - 1;
                m_axis_tready <= 1'b0;
            end
            else if (roll_gap(sink_mode))
            begin
                sink_hold     <= $urandom_range(0, 10);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
            if ($urandom_range(0, 63) == 0)
                sink_mode <= $urandom_range(0, 2);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        pix_t        seed_pixels [9];
        int          phase;
        int unsigned frames;
        logic [CFG_W-1:0] w_new;
        logic [CFG_W-1:0] h_new;
        seed_pixels = '{255, 0, 255, 1, 254, 128, 127, 0, 170};
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < TAPS; i++)
            win[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        fork
            begin
                // reset frame size: only the row lag can be seen in a short run
                for (int i = 0; i < 644; i++)
                    push_item(KIND_PIXEL, random_pixel(2));
                wait_idle();

                write_reg(REG_FRAME_WIDTH, CFG_W'(3));
                write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
                push_item(KIND_FLUSH, pix_t'(255));
                for (int i = 0; i < 9; i++)
                begin
                    if (i == 4)
                        push_item(KIND_FLUSH, pix_t'(0));
                    push_item(KIND_PIXEL, seed_pixels[i]);
                end
                push_item(KIND_PIXEL, pix_t'(85));
                for (int i = 0; i < 4; i++)
                    push_item(KIND_FLUSH, random_pixel(2));
                push_item(KIND_FLUSH, pix_t'(255));
                wait_idle();

                phase = 0;
                while (random_items < RANDOM_ITEMS)
                begin
                    calm = (random_items > RANDOM_ITEMS * 4 / 5);
                    if (phase == 2 || phase == 4 || phase == 6)
                    begin
                        if (phase == 2)
                        begin
                            write_reg(REG_FRAME_WIDTH, CFG_W'(8191));
                            write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
                        end
                        else if (phase == 4)
                        begin
                            write_reg(REG_FRAME_WIDTH, CFG_W'(4096));
                            write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
                        end
                        else
                        begin
                            write_reg(REG_FRAME_WIDTH, CFG_W'(1));
                            write_reg(REG_FRAME_HEIGHT, CFG_W'(8191));
                        end
                        // start of a frame only: full frames of these sizes are too long
                        for (int i = 0; i < PARTIAL_ROW_ITEMS; i++)
                        begin
                            push_item(KIND_PIXEL, random_pixel(2));
                            random_items++;
                        end
                        wait_idle();
                    end
                    else
                    begin
                        w_new = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(13, 40))
                                                            : CFG_W'($urandom_range(1, 12));
                        h_new = CFG_W'($urandom_range(1, 8));
                        if (phase == 1)
                        begin
                            w_new = '0;
                            h_new = '0;
                        end
                        case ($urandom_range(0, 3))
                            0: write_reg(REG_FRAME_WIDTH, w_new);
                            1: write_reg(REG_FRAME_HEIGHT, h_new);
                            default:
                            begin
                                write_reg(REG_FRAME_HEIGHT, h_new);
                                write_reg(REG_FRAME_WIDTH, w_new);
                            end
                        endcase
                        if (clamp_dim(frame_w, MAX_WIDTH) * clamp_dim(frame_h, HEIGHT_CAP) > 480
                                || phase == 1)
                        begin
                            write_reg(REG_FRAME_WIDTH, w_new);
                            write_reg(REG_FRAME_HEIGHT, h_new);
                        end
                        if ($urandom_range(0, 11) == 0)
                            write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 8191)));
                        frames = $urandom_range(1, 3);
                        for (int unsigned f = 0; f < frames; f++)
                            queue_frame(clamp_dim(frame_w, MAX_WIDTH),
                                        clamp_dim(frame_h, HEIGHT_CAP),
                                        $urandom_range(0, 3) == 0,
                                        f + 1 == frames && $urandom_range(0, 9) == 0);
                        wait_idle();
                    end
                    phase++;
                end
                wait_idle();
            end
            begin
                while (quiet_cycles < WATCHDOG_LIMIT)
                    @(posedge clk);
            end
        join_any
        if (quiet_cycles < WATCHDOG_LIMIT && error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire
